// ----- src/lcfw_pkg.sv -----
package lcfw_pkg;

  // field widths of the request and result items
  localparam int AMOUNT_BITS = 16;
  localparam int TAG_BITS    = 8;

  // at most this many waiters are woken for one request
  localparam int MAX_WAKE      = 16;
  localparam int WAKE_CNT_BITS = $clog2(MAX_WAKE + 1);

  // request commands
  localparam logic CMD_PUT = 1'b0;
  localparam logic CMD_GET = 1'b1;

  // result status codes
  localparam logic [1:0] ST_GRANTED  = 2'd0;
  localparam logic [1:0] ST_QUEUED   = 2'd1;
  localparam logic [1:0] ST_REJECTED = 2'd2;
  localparam logic [1:0] ST_WOKEN    = 2'd3;

  // configuration register indexes
  localparam logic CFG_CAPACITY   = 1'b0;
  localparam logic CFG_INIT_LEVEL = 1'b1;

  typedef struct packed {
    logic                   command;
    logic [AMOUNT_BITS-1:0] amount;
    logic [TAG_BITS-1:0]    tag;
  } request_t;

  typedef struct packed {
    logic [1:0]             status;
    logic                   kind;
    logic [TAG_BITS-1:0]    owner_tag;
    logic [AMOUNT_BITS-1:0] level_after;
    logic                   last;
  } result_t;

  // one queued waiter
  typedef struct packed {
    logic [AMOUNT_BITS-1:0] amount;
    logic [TAG_BITS-1:0]    tag;
  } waiter_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic eval;
    logic wake;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic granted;
    logic can_wake;
  } dp_stat_t;

endpackage

// ----- src/lcfw_queue.sv -----
module lcfw_queue import lcfw_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  logic    pop,
  input  waiter_t push_data,
  output waiter_t head,
  output logic    empty,
  output logic    full
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);
  localparam logic [PTR_BITS-1:0] LAST_SLOT = PTR_BITS'(DEPTH - 1);
  localparam logic [CNT_BITS-1:0] FULL_CNT  = CNT_BITS'(DEPTH);

  waiter_t             mem [DEPTH];
  logic [PTR_BITS-1:0] rd_ptr;
  logic [PTR_BITS-1:0] rd_ptr_next;
  logic [PTR_BITS-1:0] wr_ptr;
  logic [CNT_BITS-1:0] count;

  // read pointer advances on pop, wrapping at the last slot
  always_comb begin
    rd_ptr_next = rd_ptr;
    if (pop) begin
      rd_ptr_next = (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
    end
  end

  // storage; head is read every cycle at the upcoming read pointer
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
    head <= mem[rd_ptr_next];
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      rd_ptr <= rd_ptr_next;
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign empty = (count == '0);
  assign full  = (count == FULL_CNT);

endmodule

// ----- src/lcfw_datapath.sv -----
module lcfw_datapath import lcfw_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ctrl_cmd_t              cmd,
  output dp_stat_t               stat,
  input  request_t               request,
  input  logic                   cfg_write,
  input  logic                   cfg_index,
  input  logic [AMOUNT_BITS-1:0] cfg_data,
  output logic                   result_valid,
  output result_t                result
);

  logic [AMOUNT_BITS-1:0]   level;
  logic [AMOUNT_BITS-1:0]   capacity;
  request_t                 req;
  result_t                  hold;
  logic [WAKE_CNT_BITS-1:0] wake_cnt;

  waiter_t put_front;
  waiter_t get_front;
  logic    put_empty;
  logic    put_full;
  logic    get_empty;
  logic    get_full;
  logic    push_put;
  logic    push_get;
  logic    pop_put;
  logic    pop_get;
  waiter_t push_data;

  logic [AMOUNT_BITS:0]   req_sum;
  logic                   req_fit;
  logic                   granted;
  logic [AMOUNT_BITS-1:0] level_grant;
  logic                   q_full;

  waiter_t                wake_head;
  logic                   wake_gets;
  logic                   wake_empty;
  logic [AMOUNT_BITS:0]   wake_sum;
  logic                   wake_fit;
  logic                   can_wake;
  logic [AMOUNT_BITS-1:0] level_wake;

  // request evaluation against the level
  always_comb begin
    req_sum = {1'b0, level} + {1'b0, req.amount};
    if (req.command == CMD_PUT) begin
      req_fit     = (req_sum <= {1'b0, capacity});
      granted     = put_empty && req_fit;
      level_grant = req_sum[AMOUNT_BITS-1:0];
      q_full      = put_full;
    end else begin
      req_fit     = (req.amount <= level);
      granted     = get_empty && req_fit;
      level_grant = level - req.amount;
      q_full      = get_full;
    end
  end

  // head of the opposite queue, checked for one wake step
  always_comb begin
    wake_gets  = (req.command == CMD_PUT);
    wake_head  = wake_gets ? get_front : put_front;
    wake_empty = wake_gets ? get_empty : put_empty;
    wake_sum   = {1'b0, level} + {1'b0, wake_head.amount};
    if (wake_gets) begin
      wake_fit   = (wake_head.amount <= level);
      level_wake = level - wake_head.amount;
    end else begin
      wake_fit   = (wake_sum <= {1'b0, capacity});
      level_wake = wake_sum[AMOUNT_BITS-1:0];
    end
    can_wake = !wake_empty && (wake_cnt < WAKE_CNT_BITS'(MAX_WAKE)) && wake_fit;
  end

  // queue controls
  assign push_data = '{amount: req.amount, tag: req.tag};
  assign push_put  = cmd.eval && !granted && (req.command == CMD_PUT) && !put_full;
  assign push_get  = cmd.eval && !granted && (req.command == CMD_GET) && !get_full;
  assign pop_put   = cmd.wake && can_wake && !wake_gets;
  assign pop_get   = cmd.wake && can_wake && wake_gets;

  assign stat.granted  = granted;
  assign stat.can_wake = can_wake;

  lcfw_queue #(.DEPTH(QUEUE_DEPTH)) u_put_q (
    .clk       (clk),
    .rst       (rst),
    .push      (push_put),
    .pop       (pop_put),
    .push_data (push_data),
    .head      (put_front),
    .empty     (put_empty),
    .full      (put_full)
  );

  lcfw_queue #(.DEPTH(QUEUE_DEPTH)) u_get_q (
    .clk       (clk),
    .rst       (rst),
    .push      (push_get),
    .pop       (pop_get),
    .push_data (push_data),
    .head      (get_front),
    .empty     (get_empty),
    .full      (get_full)
  );

  // level, capacity and control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      level        <= '0;
      capacity     <= '1;
      wake_cnt     <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (cfg_write && (cfg_index == CFG_CAPACITY)) begin
        capacity <= cfg_data;
      end
      if (cfg_write && (cfg_index == CFG_INIT_LEVEL)) begin
        level <= cfg_data;
      end else if (cmd.eval && granted) begin
        level <= level_grant;
      end else if (cmd.wake && can_wake) begin
        level <= level_wake;
      end
      if (cmd.eval) begin
        wake_cnt <= '0;
      end else if (cmd.wake && can_wake) begin
        wake_cnt <= wake_cnt + 1'b1;
      end
      if ((cmd.eval && !granted) || cmd.wake) begin
        result_valid <= 1'b1;
      end
    end
  end

  // request latch, held result and output register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req <= request;
    end
    if (cmd.eval) begin
      if (granted) begin
        hold <= '{status: ST_GRANTED, kind: req.command, owner_tag: req.tag,
                  level_after: level_grant, last: 1'b0};
      end else begin
        result <= '{status: q_full ? ST_REJECTED : ST_QUEUED, kind: req.command,
                    owner_tag: req.tag, level_after: level, last: 1'b1};
      end
    end
    if (cmd.wake) begin
      result <= '{status: hold.status, kind: hold.kind, owner_tag: hold.owner_tag,
                  level_after: hold.level_after, last: !can_wake};
      if (can_wake) begin
        hold <= '{status: ST_WOKEN, kind: wake_gets ? CMD_GET : CMD_PUT,
                  owner_tag: wake_head.tag, level_after: level_wake, last: 1'b0};
      end
    end
  end

  // a queued or rejected request always ends its item
  a_noqueue_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.status == ST_QUEUED || result.status == ST_REJECTED))
      |-> result.last)
    else $error("queued or rejected result without last");

  // a granted put leaves the level within capacity
  a_put_fits: assert property (@(posedge clk) disable iff (rst)
    (cmd.eval && granted && (req.command == CMD_PUT) && !cfg_write) |=> (level <= capacity))
    else $error("granted put exceeds capacity");

  // wake count stays within the per-request limit
  a_wake_limit: assert property (@(posedge clk) disable iff (rst)
    wake_cnt <= WAKE_CNT_BITS'(MAX_WAKE))
    else $error("wake count above limit");

endmodule

// ----- src/lcfw_ctrl.sv -----
module lcfw_ctrl import lcfw_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  typedef enum logic [1:0] {
    IDLE,
    EVAL,
    WAKE
  } state_t;

  state_t state;
  state_t state_next;

  // next state
  always_comb begin
    case (state)
      IDLE:    state_next = start ? EVAL : IDLE;
      EVAL:    state_next = stat.granted ? WAKE : IDLE;
      WAKE:    state_next = stat.can_wake ? WAKE : IDLE;
      default: state_next = IDLE;
    endcase
  end

  // state and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != IDLE);
    end
  end

  // commands to the datapath
  assign cmd.load = (state == IDLE) && start && !busy;
  assign cmd.eval = (state == EVAL);
  assign cmd.wake = (state == WAKE);

  // an accepted transfer always goes to evaluation
  a_accept_eval: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == EVAL))
    else $error("accepted request not evaluated");

endmodule

// ----- src/level_container_with_fifo_waiters.sv -----
// queued or rejected request: one result, registered in the evaluation state
// granted request: first result from the wake state, then one woken waiter per cycle
// a new request is taken only when idle, after any wake loop has ended
// the wake loop takes opposite-queue heads one per cycle while they fit, up to MAX_WAKE
// synchronous reset: level 0, capacity all ones, both queues empty
// results are strobed for one cycle; the receiver cannot stall
module level_container_with_fifo_waiters import lcfw_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  request_t               request,
  output logic                   result_valid,
  output result_t                result,
  input  logic                   cfg_write,
  input  logic                   cfg_index,
  input  logic [AMOUNT_BITS-1:0] cfg_data
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  lcfw_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  lcfw_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .request      (request),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule
